>>> rtl/dri_pkg.sv
// Package for the drive reversal interlock: configuration and result types,
// register indexes and the constants of the throttle-to-duty map.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package dri_pkg;

	typedef enum logic [1:0] {
		CFG_DUTY_MIN  = 2'd0,
		CFG_DUTY_MAX  = 2'd1,
		CFG_INVERT    = 2'd2,
		CFG_REV_DELAY = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]  duty_min;
		logic [7:0]  duty_max;
		logic        invert_direction;
		logic [23:0] full_reverse_delay;
	} cfg_t;

	typedef struct packed {
		logic [7:0] drive_duty;
		logic       direction_level;
		logic       paused;
	} result_t;

	localparam logic [7:0]  DUTY_MIN_RST  = 8'd60;
	localparam logic [7:0]  DUTY_MAX_RST  = 8'd200;
	localparam logic        INVERT_RST    = 1'b0;
	localparam logic [23:0] REV_DELAY_RST = 24'd110080;

	localparam logic [10:0] THROTTLE_DEAD = 11'd1000;
	localparam logic [11:0] THROTTLE_BASE = 12'd990;

	// floor(x / 1021) == (x * RECIP_M) >> RECIP_SHIFT for every x below 2^19.
	localparam logic [19:0] RECIP_M     = 20'd525829;
	localparam int          RECIP_SHIFT = 29;

	localparam logic [39:0] ROUND_254 = 40'd254;
	localparam logic [7:0]  DUTY_FULL = 8'd255;

endpackage

>>> rtl/drive_reversal_interlock.sv
// Drive reversal interlock: throttle-to-duty map with a coast-down pause on direction changes.
// Each accepted item passes the input, product and quotient registers, then the result
// register, where its result is valid.
// Throughput: one item per cycle; the pipeline stalls only when the output register holds
// a result that is not taken.
// Reset: arst_n clears the pipeline and direction state and loads the configuration values.
`timescale 1ns / 1ps

module drive_reversal_interlock (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [10:0] throttle_width,
	input  logic        reverse_request,
	input  logic [31:0] now_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  drive_duty,
	output logic        direction_level,
	output logic        paused,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import dri_pkg::*;

	cfg_t    cfg;
	result_t result;

	logic s1_v, s2_v, s3_v, out_v;
	logic r2, r3, r_out;
	logic commit;

	logic [10:0] thr_s1;
	logic        rr_s1, rr_s2, rr_s3;
	logic [31:0] now_s1, now_s2, now_s3;
	logic [7:0]  duty;

	result_t out_q;

	assign cfg_ready = 1'b1;

	assign r_out    = !out_v || out_ready;
	assign r3       = !s3_v || r_out;
	assign r2       = !s2_v || r3;
	assign in_ready = !s1_v || r2;
	assign commit   = s3_v && r_out;

	dri_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v  <= 1'b0;
			s2_v  <= 1'b0;
			s3_v  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_v <= in_valid;
			end
			if (r2) begin
				s2_v <= s1_v;
			end
			if (r3) begin
				s3_v <= s2_v;
			end
			if (r_out) begin
				out_v <= s3_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			thr_s1 <= throttle_width;
			rr_s1  <= reverse_request;
			now_s1 <= now_ticks;
		end
		if (r2) begin
			rr_s2  <= rr_s1;
			now_s2 <= now_s1;
		end
		if (r3) begin
			rr_s3  <= rr_s2;
			now_s3 <= now_s2;
		end
		if (commit) begin
			out_q <= result;
		end
	end

	dri_duty_map u_map (
		.clk         (clk),
		.en_s2       (r2),
		.en_s3       (r3),
		.throttle_s1 (thr_s1),
		.cfg         (cfg),
		.duty        (duty)
	);

	dri_interlock u_lock (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (commit),
		.cfg         (cfg),
		.reverse_req (rr_s3),
		.now         (now_s3),
		.duty        (duty),
		.result      (result)
	);

	assign out_valid       = out_v;
	assign drive_duty      = out_q.drive_duty;
	assign direction_level = out_q.direction_level;
	assign paused          = out_q.paused;

	a_paused_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && out_q.paused |-> out_q.drive_duty == '0)
		else $error("paused result carries a nonzero duty");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v |-> in_ready)
		else $error("input stalled while the output register is empty");

	a_s3_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s3_v && out_v && !out_ready |=> s3_v)
		else $error("last stage item lost during an output stall");

endmodule

>>> rtl/dri_cfg_regs.sv
// Configuration registers of the drive reversal interlock.
// Depends on dri_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module dri_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [23:0]   wr_data,
	output dri_pkg::cfg_t cfg
);
	import dri_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_min           <= DUTY_MIN_RST;
			cfg_q.duty_max           <= DUTY_MAX_RST;
			cfg_q.invert_direction   <= INVERT_RST;
			cfg_q.full_reverse_delay <= REV_DELAY_RST;
		end else if (wr_en) begin
			case (cfg_index_t'(wr_index))
				CFG_DUTY_MIN:  cfg_q.duty_min           <= wr_data[7:0];
				CFG_DUTY_MAX:  cfg_q.duty_max           <= wr_data[7:0];
				CFG_INVERT:    cfg_q.invert_direction   <= wr_data[0];
				CFG_REV_DELAY: cfg_q.full_reverse_delay <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/dri_duty_map.sv
// Two-stage throttle-to-duty map: span product, then reciprocal division by
// 1021, with dead band, sign, offset and saturation after the second stage.
// Depends on dri_pkg for the map constants and cfg_t.
`timescale 1ns / 1ps

module dri_duty_map (
	input  logic          clk,
	input  logic          en_s2,
	input  logic          en_s3,
	input  logic [10:0]   throttle_s1,
	input  dri_pkg::cfg_t cfg,
	output logic [7:0]    duty
);
	import dri_pkg::*;

	logic [11:0] diff;
	logic [8:0]  span;
	logic        span_neg;
	logic [7:0]  span_mag;
	logic [18:0] mag;

	logic        low_s2;
	logic        neg_s2;
	logic [18:0] mag_s2;

	logic [38:0] recip_prod;

	logic        low_s3;
	logic        neg_s3;
	logic [8:0]  quot_s3;

	logic [10:0] val;

	always_comb begin
		diff     = {1'b0, throttle_s1} - THROTTLE_BASE;
		span     = {1'b0, cfg.duty_max} - {1'b0, cfg.duty_min};
		span_neg = span[8];
		span_mag = span_neg ? 8'(-span) : span[7:0];
		mag      = 19'(diff[10:0]) * 19'(span_mag);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			low_s2 <= (throttle_s1 <= THROTTLE_DEAD);
			neg_s2 <= span_neg;
			mag_s2 <= mag;
		end
	end

	assign recip_prod = 39'(mag_s2) * 39'(RECIP_M);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			low_s3  <= low_s2;
			neg_s3  <= neg_s2;
			quot_s3 <= recip_prod[RECIP_SHIFT +: 9];
		end
	end

	always_comb begin
		if (neg_s3) begin
			val = {3'b000, cfg.duty_min} - {2'b00, quot_s3};
		end else begin
			val = {3'b000, cfg.duty_min} + {2'b00, quot_s3};
		end
		if (low_s3 || val[10]) begin
			duty = '0;
		end else if (val[9:8] != 2'b00) begin
			duty = DUTY_FULL;
		end else begin
			duty = val[7:0];
		end
	end

endmodule

>>> rtl/dri_interlock.sv
// Direction interlock: holds direction, start and last time and the previous
// duty, and decides each item's result from them.
// Depends on dri_pkg for cfg_t and result_t.
`timescale 1ns / 1ps

module dri_interlock (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  dri_pkg::cfg_t    cfg,
	input  logic             reverse_req,
	input  logic [31:0]      now,
	input  logic [7:0]       duty,
	output dri_pkg::result_t result
);
	import dri_pkg::*;

	logic        rev_q;
	logic [31:0] start_q;
	logic [31:0] last_q;
	logic [7:0]  prev_duty_q;

	logic        want;
	logic [31:0] start_eff;
	logic [31:0] elapsed;
	logic [31:0] delay_prod;
	logic [39:0] elapsed_255;
	logic        done;
	logic        changing;
	logic        next_rev;
	logic        next_paused;
	logic [31:0] next_start;

	// The delay is floor(prod / 255); elapsed >= it exactly when
	// 255 * elapsed + 254 >= prod.
	always_comb begin
		want        = reverse_req ^ cfg.invert_direction;
		start_eff   = (last_q == '0) ? now : start_q;
		elapsed     = now - start_eff;
		delay_prod  = 32'(prev_duty_q) * 32'(cfg.full_reverse_delay);
		elapsed_255 = {elapsed, 8'h00} - {8'h00, elapsed};
		done        = (elapsed_255 + ROUND_254) >= {8'h00, delay_prod};
		changing    = (want != rev_q);
		next_rev    = (changing && done) ? want : rev_q;
		next_paused = changing && !done;
		next_start  = changing ? start_eff : now;

		result.drive_duty      = next_paused ? '0 : duty;
		result.direction_level = next_rev;
		result.paused          = next_paused;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q       <= 1'b0;
			start_q     <= '0;
			last_q      <= '0;
			prev_duty_q <= '0;
		end else if (commit) begin
			rev_q       <= next_rev;
			start_q     <= next_start;
			last_q      <= now;
			prev_duty_q <= duty;
		end
	end

endmodule

>>> tb/sv/interlock_check_pkg.sv
// Scoreboard for the drive reversal interlock: predicts the result of every accepted item
// and checks the results that the block returns, oldest first.
// Depends on dri_pkg for the register indexes, the result type and the reset values.
`timescale 1ns / 1ps

package interlock_check_pkg;

	import dri_pkg::*;

	class interlock_scoreboard;
		logic [7:0]  duty_min;
		logic [7:0]  duty_max;
		logic        invert;
		logic [23:0] rev_delay;

		logic        is_reversed;
		logic        is_paused;
		logic [31:0] start_ticks;
		logic [31:0] last_ticks;
		logic [7:0]  prev_duty;

		result_t     expected_q[$];
		int          mismatches;
		int          items_seen;
		int          results_seen;
		int          paused_items;
		int          flips_seen;
		int          writes_seen;

		function new();
			duty_min     = DUTY_MIN_RST;
			duty_max     = DUTY_MAX_RST;
			invert       = INVERT_RST;
			rev_delay    = REV_DELAY_RST;
			is_reversed  = 1'b0;
			is_paused    = 1'b0;
			start_ticks  = '0;
			last_ticks   = '0;
			prev_duty    = '0;
			mismatches   = 0;
			items_seen   = 0;
			results_seen = 0;
			paused_items = 0;
			flips_seen   = 0;
			writes_seen  = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [23:0] data);
			case (idx)
				CFG_DUTY_MIN:  duty_min  = data[7:0];
				CFG_DUTY_MAX:  duty_max  = data[7:0];
				CFG_INVERT:    invert    = data[0];
				CFG_REV_DELAY: rev_delay = data;
				default: ;
			endcase
			writes_seen++;
		endfunction

		function logic [7:0] map_duty(logic [10:0] width);
			int span;
			int val;
			if (width <= THROTTLE_DEAD)
				return 8'd0;
			span = int'(duty_max) - int'(duty_min);
			val = ((int'(width) - int'(THROTTLE_BASE)) * span) / 1021 + int'(duty_min);
			if (val < 0)
				val = 0;
			if (val > 255)
				val = 255;
			return val[7:0];
		endfunction

		function void note_item(logic [10:0] width, logic req, logic [31:0] now);
			logic              want;
			logic [31:0]       diff;
			longint unsigned   elapsed;
			longint unsigned   coast;
			longint unsigned   duty_wide;
			longint unsigned   delay_wide;
			logic [7:0]        duty;
			result_t           res;
			want = req ^ invert;
			if (last_ticks == 32'd0)
				start_ticks = now;
			last_ticks = now;
			duty_wide = 64'(prev_duty);
			delay_wide = 64'(rev_delay);
			coast = (duty_wide * delay_wide) / 255;
			if (want != is_reversed) begin
				is_paused = 1'b1;
				diff = last_ticks - start_ticks;
				elapsed = 64'(diff);
				if (elapsed >= coast) begin
					is_reversed = want;
					is_paused = 1'b0;
					flips_seen++;
				end else begin
					paused_items++;
				end
			end else begin
				start_ticks = last_ticks;
				is_paused = 1'b0;
			end
			duty = map_duty(width);
			prev_duty = duty;
			res.drive_duty = is_paused ? 8'd0 : duty;
			res.direction_level = is_reversed;
			res.paused = is_paused;
			expected_q.push_back(res);
			items_seen++;
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH: %s", what);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with no item pending: duty %0d dir %b paused %b",
					got.drive_duty, got.direction_level, got.paused));
				return;
			end
			want = expected_q.pop_front();
			results_seen++;
			if (got.drive_duty !== want.drive_duty)
				report($sformatf("result %0d drive_duty: got %0d, want %0d",
					results_seen, got.drive_duty, want.drive_duty));
			if (got.direction_level !== want.direction_level)
				report($sformatf("result %0d direction_level: got %b, want %b",
					results_seen, got.direction_level, want.direction_level));
			if (got.paused !== want.paused)
				report($sformatf("result %0d paused: got %b, want %b",
					results_seen, got.paused, want.paused));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

>>> tb/sv/tb_top.sv
// Top-level testbench for drive_reversal_interlock: directed and random items under
// random idling on both sides, several register settings and one long output stall.
// Depends on dri_pkg, interlock_check_pkg and the block itself.
`timescale 1ns / 1ps

module tb_top;

	import dri_pkg::*;
	import interlock_check_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [10:0] throttle_width;
	logic        reverse_request;
	logic [31:0] now_ticks;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  drive_duty;
	logic        direction_level;
	logic        paused;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	interlock_scoreboard sb;
	int          cycle_count = 0;
	logic        idle_on = 1'b1;
	logic        hold_req = 1'b0;
	logic        hold_taken = 1'b0;
	logic [31:0] ticks_now = '0;
	logic        dir_req = 1'b0;

	drive_reversal_interlock dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.throttle_width  (throttle_width),
		.reverse_request (reverse_request),
		.now_ticks       (now_ticks),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.drive_duty      (drive_duty),
		.direction_level (direction_level),
		.paused          (paused),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.drive_duty = drive_duty;
				got.direction_level = direction_level;
				got.paused = paused;
				sb.check_result(got);
			end
			if (in_valid && in_ready)
				sb.note_item(throttle_width, reverse_request, now_ticks);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
		end
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic send_item(logic [10:0] w, logic r, logic [31:0] t);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		throttle_width = w;
		reverse_request = r;
		now_ticks = t;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic program_reg(cfg_index_t idx, logic [23:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(logic [7:0] dmin, logic [7:0] dmax, logic inv, logic [23:0] delay);
		program_reg(CFG_DUTY_MIN, {16'($urandom), dmin});
		program_reg(CFG_DUTY_MAX, {16'($urandom), dmax});
		program_reg(CFG_INVERT, {23'($urandom), inv});
		program_reg(CFG_REV_DELAY, delay);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers change only once every result is back and the pipeline has drained.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Requests mostly hold a direction for a while so that coast-downs run to the end;
	// a tenth of the items carry a random request as noise.
	task automatic run_random(int count, int step_max);
		logic [10:0] w;
		logic        r;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0: w = 11'($urandom_range(0, 1000));
				1: w = 11'($urandom_range(995, 1010));
				2: w = $urandom_range(0, 1) ? 11'd2011 : 11'd2047;
				default: w = 11'($urandom_range(1001, 2047));
			endcase
			if ($urandom_range(0, 9) == 0)
				dir_req = ~dir_req;
			if ($urandom_range(0, 9) == 0)
				r = 1'($urandom_range(0, 1));
			else
				r = dir_req;
			case ($urandom_range(0, 39))
				0: ticks_now = '0;
				1: ticks_now = $urandom();
				2: ticks_now = ticks_now - $urandom_range(0, step_max);
				3: ticks_now = 32'hFFFF_FFFF - $urandom_range(0, step_max);
				default: ticks_now = ticks_now + $urandom_range(0, step_max);
			endcase
			send_item(w, r, ticks_now);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		throttle_width = '0;
		reverse_request = 1'b0;
		now_ticks = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DUTY_MIN;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: dead band, map ends, a full coast-down, time zero and wrap.
		send_item(11'd0, 1'b0, 32'd0);
		send_item(11'd1000, 1'b0, 32'd100);
		send_item(11'd1001, 1'b0, 32'd200);
		send_item(11'd2011, 1'b0, 32'd300);
		send_item(11'd2047, 1'b0, 32'd400);
		send_item(11'd2047, 1'b1, 32'd500);
		send_item(11'd1500, 1'b1, 32'd40000);
		send_item(11'd1500, 1'b1, 32'd90000);
		send_item(11'd1500, 1'b0, 32'd90100);
		send_item(11'd0, 1'b0, 32'd0);
		send_item(11'd0, 1'b1, 32'd5000);
		send_item(11'd2047, 1'b1, 32'hFFFF_FFFF);
		send_item(11'd2047, 1'b0, 32'h0000_0010);
		send_item(11'd999, 1'b0, 32'h0000_0020);
		run_random(120, 30000);

		// Minimum above maximum, inverted request and no coast-down wait.
		settle();
		set_config(8'd200, 8'd10, 1'b1, 24'd0);
		send_item(11'd2047, 1'b0, 32'd1000);
		send_item(11'd1200, 1'b1, 32'd1001);
		send_item(11'd1001, 1'b0, 32'd1002);
		send_item(11'd2047, 1'b1, 32'd1003);
		run_random(150, 30000);

		settle();
		set_config(8'd0, 8'd255, 1'b0, 24'hFF_FFFF);
		run_random(150, 2000000);

		settle();
		set_config(8'd255, 8'd255, 1'b0, 24'd1000);
		hold_req = 1'b1;
		run_random(150, 3000);

		settle();
		set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFF_FFFF)));
		run_random(150, $urandom_range(1000, 500000));

		settle();
		set_config(8'd0, 8'd0, 1'b1, 24'd50000);
		run_random(150, 20000);

		settle();
		set_config(DUTY_MIN_RST, DUTY_MAX_RST, INVERT_RST, REV_DELAY_RST);
		idle_on = 1'b0;
		run_random(180, 30000);

		settle();
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("Summary: %0d items and %0d results checked, %0d register writes.",
			sb.items_seen, sb.results_seen, sb.writes_seen);
		$display("Coast-down: %0d items held paused, %0d direction changes completed.",
			sb.paused_items, sb.flips_seen);
		if (sb.mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
